// ===== rtl/ilist_pkg.sv =====
// Shared types and constants for the indexed list engine.
`timescale 1ns / 1ps
package ilist_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int ELEM_W_DEF    = 32;

	localparam int KIND_W        = 3;
	localparam int POS_W         = 7;
	localparam int ELEM_PORT_W   = 32;
	localparam int STAT_W        = 2;
	localparam int CNT_PORT_W    = 7;
	localparam int FPOS_W        = 6;
	// wide enough for any count up to the largest supported capacity
	localparam int CNT_MAX_W     = 11;

	typedef enum logic [KIND_W-1:0] {
		K_APPEND = 3'd0,
		K_INSERT = 3'd1,
		K_READ   = 3'd2,
		K_WRITE  = 3'd3,
		K_REMOVE = 3'd4,
		K_FIND   = 3'd5,
		K_CLEAR  = 3'd6
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_WRITE,
		OP_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic                   capture;
		logic [CNT_MAX_W-1:0]   pos;
		logic [CNT_MAX_W-1:0]   cnt;
	} cell_ctl_t;

endpackage

// ===== rtl/ilist_cell.sv =====
// One list slot: holds an entry, shifts with its neighbors, taps and compares.
`timescale 1ns / 1ps
module ilist_cell #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                           clk,
	input  ilist_pkg::cell_ctl_t           ctl,
	input  logic [ilist_pkg::CNT_MAX_W-1:0] idx,
	input  logic [ELEM_WIDTH-1:0]          elem,
	input  logic [ELEM_WIDTH-1:0]          data_lo,
	input  logic [ELEM_WIDTH-1:0]          data_hi,
	output logic [ELEM_WIDTH-1:0]          data,
	output logic [ELEM_WIDTH-1:0]          tap,
	output logic                           match
);
	import ilist_pkg::*;

	logic [ELEM_WIDTH-1:0] data_q;
	logic [ELEM_WIDTH-1:0] tap_q;
	logic                  match_q;
	logic                  at_pos;
	logic                  above_pos;

	assign at_pos    = (idx == ctl.pos);
	assign above_pos = (idx > ctl.pos);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_INSERT: begin
				if (at_pos) begin
					data_q <= elem;
				end else if (above_pos) begin
					data_q <= data_lo;
				end
			end
			OP_WRITE: begin
				if (at_pos) begin
					data_q <= elem;
				end
			end
			OP_REMOVE: begin
				if (at_pos || above_pos) begin
					data_q <= data_hi;
				end
			end
			default: begin
			end
		endcase
	end

	// capture the pre-update view for the response cycle
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			tap_q   <= at_pos ? data_q : '0;
			match_q <= (idx < ctl.cnt) && (data_q == elem);
		end
	end

	assign data  = data_q;
	assign tap   = tap_q;
	assign match = match_q;

endmodule

// ===== rtl/indexed_list_engine.sv =====
// Top level of the indexed list engine: command control and the row of list cells.
`timescale 1ns / 1ps
//
//  channel   direction  handshake          word
//  command   in         start / busy       kind, position, element
//  result    out        done (strobe)      status, value, found, found_position,
//                                          count, empty_res
//
//  A word is taken at the edge where start is high and busy is low.
//  Each word goes through accept, execute (all cells shift or load at
//  once and capture their read tap and compare bit), and result. The next word
//  may be accepted in the result cycle, while the previous one is answered;
//  busy is high only in the execute cycle.
//  done is high for exactly one cycle per word; the receiver cannot stall.
//  Reset clears the count; entry contents are left as they are and are never
//  read before being written.
module indexed_list_engine #(
	parameter int CAPACITY   = ilist_pkg::CAPACITY_DEF,
	parameter int ELEM_WIDTH = ilist_pkg::ELEM_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ilist_pkg::KIND_W-1:0]      kind,
	input  logic [ilist_pkg::POS_W-1:0]       position,
	input  logic [ilist_pkg::ELEM_PORT_W-1:0] element,
	output logic                              done,
	output logic [ilist_pkg::STAT_W-1:0]      status,
	output logic [ilist_pkg::ELEM_PORT_W-1:0] value,
	output logic                              found,
	output logic [ilist_pkg::FPOS_W-1:0]      found_position,
	output logic [ilist_pkg::CNT_PORT_W-1:0]  count,
	output logic                              empty_res
);
	import ilist_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// FSM
	state_t state_q, state_nxt;
	logic   accept;

	// command word held through execute and result
	logic [KIND_W-1:0]     kind_q;
	logic [POS_W-1:0]      pos_q;
	logic [ELEM_WIDTH-1:0] elem_q;

	// list occupancy and per-word status
	logic [CW-1:0]         count_q, count_nxt;
	status_t               status_q, status_nxt;

	cell_ctl_t             ctl;
	logic [CNT_MAX_W-1:0]  pos_x;
	logic [CNT_MAX_W-1:0]  cnt_x;
	logic                  full;

	logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [ELEM_WIDTH-1:0] cell_tap  [CAPACITY];
	logic [CAPACITY-1:0]   cell_match;

	logic [ELEM_WIDTH-1:0] tap_or;
	logic                  hit;
	logic [CNT_MAX_W-1:0]  hit_pos;

	// ---------------------------------------------------------------
	// Sequencer: idle -> execute -> result, with a new word allowed in
	// the result cycle.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		busy      = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				busy      = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				done      = 1'b1;
				state_nxt = start ? S_EXEC : S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign accept = start && !busy;

	// hold the command word
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			pos_q  <= position;
			elem_q <= ELEM_WIDTH'(element);
		end
	end

	// ---------------------------------------------------------------
	// Execute: check range and fill, then broadcast one cell operation.
	// Append is an insert at the current count.
	// ---------------------------------------------------------------
	assign pos_x = CNT_MAX_W'(pos_q);
	assign cnt_x = CNT_MAX_W'(count_q);
	assign full  = (cnt_x >= CNT_MAX_W'(CAPACITY));

	always_comb begin
		status_nxt  = ST_OK;
		count_nxt   = count_q;
		ctl.op      = OP_HOLD;
		ctl.capture = (state_q == S_EXEC);
		ctl.pos     = pos_x;
		ctl.cnt     = cnt_x;
		unique case (kind_q)
			K_APPEND: begin
				ctl.pos = cnt_x;
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.op    = OP_INSERT;
					count_nxt = count_q + CW'(1);
				end
			end
			K_INSERT: begin
				priority if (pos_x > cnt_x) begin
					status_nxt = ST_RANGE;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.op    = OP_INSERT;
					count_nxt = count_q + CW'(1);
				end
			end
			K_READ: begin
				if (pos_x >= cnt_x) begin
					status_nxt = ST_RANGE;
				end
			end
			K_WRITE: begin
				if (pos_x >= cnt_x) begin
					status_nxt = ST_RANGE;
				end else begin
					ctl.op = OP_WRITE;
				end
			end
			K_REMOVE: begin
				if (pos_x >= cnt_x) begin
					status_nxt = ST_RANGE;
				end else begin
					ctl.op    = OP_REMOVE;
					count_nxt = count_q - CW'(1);
				end
			end
			K_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				// find and the unused code change nothing here
			end
		endcase
		// drop everything outside the execute cycle
		if (state_q != S_EXEC) begin
			ctl.op    = OP_HOLD;
			count_nxt = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_q <= status_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Row of cells: each takes its lower neighbor on insert and its
	// upper neighbor on remove. The ends see zero.
	// ---------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] lo;
		logic [ELEM_WIDTH-1:0] hi;

		if (i == 0) begin : g_first
			assign lo = '0;
		end else begin : g_mid_lo
			assign lo = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign hi = '0;
		end else begin : g_mid_hi
			assign hi = cell_data[i+1];
		end

		ilist_cell #(
			.ELEM_WIDTH(ELEM_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.idx     (CNT_MAX_W'(i)),
			.elem    (elem_q),
			.data_lo (lo),
			.data_hi (hi),
			.data    (cell_data[i]),
			.tap     (cell_tap[i]),
			.match   (cell_match[i])
		);
	end

	// ---------------------------------------------------------------
	// Result: merge the captured taps and pick the lowest matching cell.
	// ---------------------------------------------------------------
	always_comb begin
		tap_or  = '0;
		hit     = 1'b0;
		hit_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tap_or = tap_or | cell_tap[i];
		end
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit     = 1'b1;
				hit_pos = CNT_MAX_W'(i);
			end
		end
	end

	always_comb begin
		status         = status_q;
		value          = '0;
		found          = 1'b0;
		found_position = '0;
		if (status_q == ST_OK && (kind_q == K_READ || kind_q == K_REMOVE)) begin
			value = ELEM_PORT_W'(tap_or);
		end
		if (kind_q == K_FIND && hit) begin
			found          = 1'b1;
			found_position = FPOS_W'(hit_pos);
		end
	end

	assign count     = CNT_PORT_W'(count_q);
	assign empty_res = (count_q == '0);

endmodule

// ===== sim/tb_indexed_list_engine.sv =====
// Self-checking testbench for the indexed list engine: directed and random list operations.
`timescale 1ns / 1ps
module tb_indexed_list_engine;
	import ilist_pkg::*;

	// Kind code that the block must answer with no change.
	localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 100000;

	// One expected answer, plus the kind of the word that caused it for reporting.
	typedef struct {
		logic [KIND_W-1:0]      op;
		status_t                st;
		logic [ELEM_PORT_W-1:0] val;
		logic                   fnd;
		logic [FPOS_W-1:0]      fpos;
		logic [CNT_PORT_W-1:0]  cnt;
		logic                   emp;
	} list_answer_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0] position;
	logic [ELEM_PORT_W-1:0] element;
	logic done;
	logic [STAT_W-1:0] status;
	logic [ELEM_PORT_W-1:0] value;
	logic found;
	logic [FPOS_W-1:0] found_position;
	logic [CNT_PORT_W-1:0] count;
	logic empty_res;

	// Shadow copy of the list contents and length, advanced once per accepted word.
	logic [ELEM_PORT_W-1:0] list_mem [CAPACITY_DEF];
	int list_len = 0;

	// Answers owed by the block, oldest first.
	list_answer_t pending_answers[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	// Insert random sender gaps while set; clear it for the back-to-back tail.
	bit gaps_on = 1'b1;

	indexed_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.element(element),
		.done(done),
		.status(status),
		.value(value),
		.found(found),
		.found_position(found_position),
		.count(count),
		.empty_res(empty_res)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Apply one operation to the shadow list and return the answer it must produce.
	function automatic list_answer_t list_apply(logic [KIND_W-1:0] op, logic [POS_W-1:0] pos,
			logic [ELEM_PORT_W-1:0] word);
		list_answer_t a;
		int i;
		a.op = op;
		a.st = ST_OK;
		a.val = '0;
		a.fnd = 1'b0;
		a.fpos = '0;
		case (op)
			K_APPEND: begin
				if (list_len >= CAPACITY_DEF) begin
					a.st = ST_FULL;
				end else begin
					list_mem[list_len] = word;
					list_len++;
				end
			end
			K_INSERT: begin
				// range check wins over the full check
				if (pos > list_len) begin
					a.st = ST_RANGE;
				end else if (list_len >= CAPACITY_DEF) begin
					a.st = ST_FULL;
				end else begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = word;
					list_len++;
				end
			end
			K_READ: begin
				if (pos >= list_len)
					a.st = ST_RANGE;
				else
					a.val = list_mem[pos];
			end
			K_WRITE: begin
				if (pos >= list_len)
					a.st = ST_RANGE;
				else
					list_mem[pos] = word;
			end
			K_REMOVE: begin
				if (pos >= list_len) begin
					a.st = ST_RANGE;
				end else begin
					a.val = list_mem[pos];
					for (i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			K_FIND: begin
				// first match below the count only
				for (i = 0; i < list_len && !a.fnd; i++) begin
					if (list_mem[i] == word) begin
						a.fnd = 1'b1;
						a.fpos = i[FPOS_W-1:0];
					end
				end
			end
			K_CLEAR: list_len = 0;
			default: ;
		endcase
		a.cnt = list_len[CNT_PORT_W-1:0];
		a.emp = (list_len == 0);
		return a;
	endfunction

	// Offer one word, hold it until the block takes it, then log the answer it owes.
	task automatic send_word(logic [KIND_W-1:0] op, logic [POS_W-1:0] pos,
			logic [ELEM_PORT_W-1:0] word);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		kind <= op;
		position <= pos;
		element <= word;
		// busy read here is the value of the cycle that this edge closes
		do @(posedge clk); while (busy);
		pending_answers.push_back(list_apply(op, pos, word));
	endtask

	// Drop start and wait until every owed answer is in, plus the result latency.
	task automatic wait_all_answers();
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t: %s", $realtime, msg);
	endtask

	// Every operation but append against an empty list, including the unused kind.
	task automatic test_empty_list();
		send_word(K_READ, 7'd0, 32'h0);
		send_word(K_WRITE, 7'd0, 32'hDEAD_BEEF);
		send_word(K_REMOVE, 7'd0, 32'h0);
		send_word(K_FIND, 7'd0, 32'h0);
		send_word(K_INSERT, 7'd1, 32'h1234_5678);
		send_word(K_INSERT, 7'd127, 32'hFFFF_FFFF);
		send_word(K_UNUSED, 7'd127, 32'hFFFF_FFFF);
		send_word(K_CLEAR, 7'd0, 32'h0);
	endtask

	// Each edit in a small list: ends, middle, duplicates, out-of-range hits.
	task automatic test_edit_ops();
		send_word(K_APPEND, 7'd0, 32'h0000_0000);
		send_word(K_APPEND, 7'd127, 32'hFFFF_FFFF);
		send_word(K_INSERT, 7'd0, 32'hA5A5_A5A5);
		send_word(K_INSERT, 7'd3, 32'h5A5A_5A5A);
		send_word(K_INSERT, 7'd2, 32'hFFFF_FFFF);
		send_word(K_READ, 7'd0, 32'h0);
		send_word(K_READ, 7'd4, 32'h0);
		send_word(K_WRITE, 7'd1, 32'h8000_0001);
		// two copies of all-ones: the lower one must win
		send_word(K_FIND, 7'd0, 32'hFFFF_FFFF);
		send_word(K_FIND, 7'd0, 32'h7FFF_FFFE);
		send_word(K_REMOVE, 7'd0, 32'h0);
		send_word(K_REMOVE, 7'd3, 32'h0);
		send_word(K_READ, 7'd3, 32'h0);
		send_word(K_READ, 7'd127, 32'h0);
		send_word(K_WRITE, 7'd64, 32'h1);
		send_word(K_UNUSED, 7'd0, 32'h0);
		send_word(K_CLEAR, 7'd0, 32'h0);
	endtask

	// Fill to capacity, hit the full and range checks there, then work the top slot.
	task automatic test_full_list();
		repeat (CAPACITY_DEF) send_word(K_APPEND, 7'($urandom_range(0, 127)), $urandom());
		send_word(K_APPEND, 7'd0, 32'h1);
		send_word(K_INSERT, 7'd64, 32'h2);
		send_word(K_INSERT, 7'd0, 32'h3);
		send_word(K_INSERT, 7'd65, 32'h4);
		send_word(K_FIND, 7'd0, list_mem[CAPACITY_DEF-1]);
		send_word(K_READ, 7'd63, 32'h0);
		send_word(K_WRITE, 7'd63, 32'hC0DE_0063);
		send_word(K_REMOVE, 7'd63, 32'h0);
		send_word(K_INSERT, 7'd63, 32'hFFFF_FFFF);
		send_word(K_REMOVE, 7'd0, 32'h0);
		send_word(K_CLEAR, 7'd0, 32'h0);
	endtask

	// Random walk of the list length toward moving targets, with a share of bad positions.
	task automatic test_random_ops(int n_words);
		int target;
		int pick;
		logic [KIND_W-1:0] op;
		logic [POS_W-1:0] pos;
		logic [ELEM_PORT_W-1:0] word;
		target = $urandom_range(0, CAPACITY_DEF);
		repeat (n_words) begin
			if (list_len == target) begin
				if ($urandom_range(0, 3) == 0)
					target = $urandom_range(0, 1) ? CAPACITY_DEF : 0;
				else
					target = $urandom_range(0, CAPACITY_DEF);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				op = (list_len < target) ? ($urandom_range(0, 1) ? K_APPEND : K_INSERT) : K_REMOVE;
			else if (pick < 54)
				op = K_READ;
			else if (pick < 66)
				op = K_WRITE;
			else if (pick < 81)
				op = K_FIND;
			else if (pick < 89)
				op = $urandom_range(0, 1) ? K_APPEND : K_INSERT;
			else if (pick < 97)
				op = K_REMOVE;
			else if (pick < 99)
				op = K_CLEAR;
			else
				op = K_UNUSED;

			// mostly legal positions, the rest anywhere in the field
			if ($urandom_range(0, 99) < 15)
				pos = 7'($urandom_range(0, 127));
			else if (op == K_INSERT)
				pos = 7'($urandom_range(0, list_len));
			else
				pos = (list_len > 0) ? 7'($urandom_range(0, list_len - 1)) : 7'd0;

			// small values give duplicates, so find sees repeated words
			if (op == K_FIND && list_len > 0 && $urandom_range(0, 99) < 60)
				word = list_mem[$urandom_range(0, list_len - 1)];
			else if ($urandom_range(0, 1))
				word = $urandom_range(0, 15);
			else
				word = $urandom();
			send_word(op, pos, word);
		end
	endtask

	// Compare each strobed result against the oldest owed answer.
	always @(posedge clk) begin : check_answers
		list_answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				note_mismatch("result strobe with no operation outstanding");
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.st || value !== want.val || found !== want.fnd
						|| found_position !== want.fpos || count !== want.cnt
						|| empty_res !== want.emp)
					note_mismatch($sformatf({"kind %0d: expected st %0d val %h fnd %0b fpos %0d ",
						"cnt %0d emp %0b, got st %0d val %h fnd %0b fpos %0d cnt %0d emp %0b"},
						want.op, want.st, want.val, want.fnd, want.fpos, want.cnt, want.emp,
						status, value, found, found_position, count, empty_res));
			end
		end
	end

	// Bound the run so a hung handshake cannot spin forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		// Hold every input at a known value through reset.
		start <= 1'b0;
		kind <= K_APPEND;
		position <= '0;
		element <= '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edit_ops();
		test_full_list();
		// Pause the sender until the block has answered everything.
		wait_all_answers();
		test_random_ops(450);
		// Finish with no gaps so words go at the block's full rate.
		gaps_on = 1'b0;
		test_random_ops(100);
		wait_all_answers();

		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ilist_pkg.sv
rtl/ilist_cell.sv
rtl/indexed_list_engine.sv
sim/tb_indexed_list_engine.sv
